[rtl/core/hfi_pkg.sv]
// Shared types and constants for the HFI rotor angle estimator.
`default_nettype none
package hfi_pkg;

  localparam int MW = 33;
  localparam int PW = 2 * MW;

  typedef enum logic [4:0] {
    S_IDLE,
    S_Q0, S_Q1, S_Q2, S_Q3, S_Q4,
    S_T0, S_T1, S_T2, S_T3, S_T4, S_T5, S_T6,
    S_T7, S_T8, S_T9, S_T10, S_T11, S_T12,
    S_D0, S_D1, S_D2, S_D3,
    S_V0, S_V1, S_V2, S_OUT
  } state_t;

  localparam logic [2:0] CFG_PROP_GAIN   = 3'd0;
  localparam logic [2:0] CFG_INTEG_GAIN  = 3'd1;
  localparam logic [2:0] CFG_SPEED_LIMIT = 3'd2;
  localparam logic [2:0] CFG_INJECT_AMP  = 3'd3;
  localparam logic [2:0] CFG_BIAS_AMP    = 3'd4;
  localparam logic [2:0] CFG_LPF_B0      = 3'd5;
  localparam logic [2:0] CFG_LPF_A1      = 3'd6;
  localparam logic [2:0] CFG_LPF_A2      = 3'd7;

  // quarter-wave sine polynomial, Q15
  localparam logic signed [MW-1:0] POLY_C5 = 33'sd2320;
  localparam logic signed [MW-1:0] POLY_C3 = 33'sd21024;
  localparam logic signed [MW-1:0] POLY_C1 = 33'sd51472;

  // polarity test schedule
  localparam logic [10:0] DET_POS_START = 11'd400;
  localparam logic [10:0] DET_POS_SUM   = 11'd600;
  localparam logic [10:0] DET_POS_END   = 11'd610;
  localparam logic [10:0] DET_NEG_START = 11'd1000;
  localparam logic [10:0] DET_NEG_SUM   = 11'd1200;
  localparam logic [10:0] DET_NEG_END   = 11'd1210;
  localparam logic [19:0] SUM_MAX       = 20'hFFFFF;

  localparam logic signed [PW-1:0] P_MAX32 = 66'sh0_7FFF_FFFF;
  localparam logic signed [PW-1:0] P_MIN32 = -66'sh0_8000_0000;
  localparam logic signed [PW-1:0] P_MAX16 = 66'sd32767;
  localparam logic signed [PW-1:0] P_MIN16 = -66'sd32768;

endpackage
`default_nettype wire

[rtl/core/hfi_rotor_angle_estimator.sv]
// HFI rotor angle estimator: PLL observer and polarity test on one shared multiplier.
//
// A beat is accepted, then takes sin/cos of the estimated angle in two passes of the
// quarter-wave polynomial (states Q0 to Q4). A track beat then runs the loop (states T0
// to T12) and a detect beat the d-axis test (states D0 to D3). Both end with the voltage
// products and the output load (states V0 to V2 and OUT). All products run one at a time
// through a single registered 33x33 signed multiplier. The result sits in an output
// register, so a new beat is taken while it waits. A beat that finishes while the
// previous result is still held stalls until that result is taken. A detect beat after
// the polarity test has completed is accepted but gives no result.
`default_nettype none
module hfi_rotor_angle_estimator #(
  parameter int SINE_TABLE_BITS = 10,
  parameter int SAMPLE_WIDTH    = 16
) (
  input  wire                logic        clk,
  input  wire                logic        rst_n,
  input  wire                logic        in_valid,
  output                     logic        in_ready,
  input  wire                logic        in_kind,
  input  wire                logic signed [15:0] in_current_alpha,
  input  wire                logic signed [15:0] in_current_beta,
  output                     logic        out_valid,
  input  wire                logic        out_ready,
  output                     logic signed [15:0] out_volt_alpha,
  output                     logic signed [15:0] out_volt_beta,
  output                     logic [15:0] out_angle,
  output                     logic signed [31:0] out_speed,
  output                     logic        out_polarity_done,
  input  wire                logic        cfg_wr_en,
  input  wire                logic [2:0]  cfg_index,
  input  wire                logic [31:0] cfg_wdata
);
  import hfi_pkg::*;

  localparam int SW   = SAMPLE_WIDTH;
  localparam int TB   = SINE_TABLE_BITS;
  localparam int ZS   = 17 - TB;
  localparam int HW   = SW + 1;
  localparam int DW   = SW + 3;
  localparam int EW   = SW + 6;
  localparam int AW   = (SW + 21 > 38) ? SW + 21 : 38;
  localparam int XW   = (SW > 16) ? SW : 16;
  localparam int SUMW = (SW + 3 > 22) ? SW + 3 : 22;
  localparam int SMAX_I = (1 << (SW - 1)) - 1;
  localparam int SMIN_I = -(1 << (SW - 1));

  state_t state_r, state_nxt;

  logic [31:0] prop_gain_r, integ_gain_r;
  logic [30:0] speed_limit_r;
  logic [14:0] inject_amp_r, bias_amp_r;
  logic signed [31:0] b0_r, a1_r, a2_r;

  logic signed [SW-1:0] a_r, b_r, ad0_r, ad1_r, bd0_r, bd1_r, dd0_r, dd1_r, id_r;
  logic kind_r;
  logic signed [HW-1:0] ahp_r, bhp_r;
  logic signed [DW-1:0] dha_r, dhb_r;
  logic signed [15:0] sin_r, cos_r, amp_r, va_r, vb_r;
  logic [16:0] z_r, z2_r;
  logic qneg_r, sel_r;
  logic signed [PW-1:0] p_r;
  logic signed [AW-1:0] acc_r;
  logic signed [EW-1:0] err_r;
  logic signed [31:0] integ_r, omega_r, xh0_r, xh1_r, yh0_r, yh1_r;
  logic [31:0] angle_r;
  logic inj_sign_r, inj_phase_r;
  logic [10:0] count_r;
  logic [19:0] pos_r, neg_r;
  logic detected_r;

  logic signed [MW-1:0] ma, mb;
  logic [TB-1:0] idx;
  logic [1:0] quad;
  logic [16:0] zraw, zc, t17;
  logic [XW-1:0] ax, bx;

  logic in_beat;
  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign ax = XW'($unsigned(in_current_alpha));
  assign bx = XW'($unsigned(in_current_beta));

  assign idx  = angle_r[31 -: TB] + (sel_r ? TB'(1 << (TB - 2)) : '0);
  assign quad = idx[TB-1 -: 2];
  assign zraw = 17'(idx[TB-3:0]) << ZS;
  assign zc   = quad[0] ? (17'd32768 - zraw) : zraw;
  assign t17  = p_r[31:15];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_beat && !(in_kind && detected_r)) state_nxt = S_Q0;
      end
      S_Q0:  state_nxt = S_Q1;
      S_Q1:  state_nxt = S_Q2;
      S_Q2:  state_nxt = S_Q3;
      S_Q3:  state_nxt = S_Q4;
      S_Q4:  state_nxt = !sel_r ? S_Q0 : (kind_r ? S_D0 : S_T0);
      S_T0:  state_nxt = S_T1;
      S_T1:  state_nxt = S_T2;
      S_T2:  state_nxt = S_T3;
      S_T3:  state_nxt = S_T4;
      S_T4:  state_nxt = S_T5;
      S_T5:  state_nxt = S_T6;
      S_T6:  state_nxt = S_T7;
      S_T7:  state_nxt = S_T8;
      S_T8:  state_nxt = S_T9;
      S_T9:  state_nxt = S_T10;
      S_T10: state_nxt = S_T11;
      S_T11: state_nxt = S_T12;
      S_T12: state_nxt = S_V0;
      S_D0:  state_nxt = S_D1;
      S_D1:  state_nxt = S_D2;
      S_D2:  state_nxt = S_D3;
      S_D3:  state_nxt = S_V0;
      S_V0:  state_nxt = S_V1;
      S_V1:  state_nxt = S_V2;
      S_V2:  state_nxt = S_OUT;
      S_OUT: begin
        if (!out_valid || out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    case (state_r)
      S_Q0: begin
        ma = signed'(MW'(zc));
        mb = signed'(MW'(zc));
      end
      S_Q1: begin
        ma = POLY_C5;
        mb = signed'(MW'(t17));
      end
      S_Q2: begin
        ma = POLY_C3 - signed'(MW'(t17));
        mb = signed'(MW'(z2_r));
      end
      S_Q3: begin
        ma = POLY_C1 - signed'(MW'(t17));
        mb = signed'(MW'(z_r));
      end
      S_T1: begin
        ma = MW'(dha_r);
        mb = MW'(sin_r);
      end
      S_T2: begin
        ma = MW'(dhb_r);
        mb = MW'(cos_r);
      end
      S_T4: begin
        ma = MW'(err_r);
        mb = signed'({1'b0, integ_gain_r});
      end
      S_T5: begin
        ma = MW'(err_r);
        mb = signed'({1'b0, prop_gain_r});
      end
      S_T7: begin
        ma = MW'(omega_r);
        mb = MW'(b0_r);
      end
      S_T8: begin
        ma = MW'(xh0_r);
        mb = MW'(b0_r);
      end
      S_T9: begin
        ma = MW'(xh1_r);
        mb = MW'(b0_r);
      end
      S_T10: begin
        ma = MW'(yh0_r);
        mb = MW'(a1_r);
      end
      S_T11: begin
        ma = MW'(yh1_r);
        mb = MW'(a2_r);
      end
      S_D0: begin
        ma = MW'(a_r);
        mb = MW'(cos_r);
      end
      S_D1: begin
        ma = MW'(b_r);
        mb = MW'(sin_r);
      end
      S_V0: begin
        ma = MW'(amp_r);
        mb = MW'(cos_r);
      end
      S_V1: begin
        ma = MW'(amp_r);
        mb = MW'(sin_r);
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    p_r <= ma * mb;
  end

  // datapath
  logic signed [SW+1:0] sa, sb, sd;
  logic signed [HW-1:0] hpa, hpb;
  logic signed [DW-1:0] dha, dhb;
  logic signed [AW-1:0] ed, ysum, idw;
  logic signed [PW-1:0] iw, lim, ow, vsh;
  logic signed [31:0] y32, sat_om;
  logic signed [15:0] r16, vsat;
  logic [10:0] cnt_n;
  logic [SW+1:0] mag;
  logic [SUMW-1:0] ps, ns;
  logic new_sign;

  always_comb begin
    sa  = (SW+2)'(a_r) - ((SW+2)'(ad0_r) <<< 1) + (SW+2)'(ad1_r);
    sb  = (SW+2)'(b_r) - ((SW+2)'(bd0_r) <<< 1) + (SW+2)'(bd1_r);
    hpa = HW'(sa >>> 2);
    hpb = HW'(sb >>> 2);
    dha = DW'(hpa) - DW'(ahp_r);
    dhb = DW'(hpb) - DW'(bhp_r);
    if (!inj_sign_r) begin
      dha = -dha;
      dhb = -dhb;
    end
    ed  = (acc_r - AW'(p_r)) >>> 15;
    lim = signed'(PW'(speed_limit_r));
    iw  = PW'(integ_r) + p_r;
    if (iw > lim) iw = lim;
    else if (iw < -lim) iw = -lim;
    ow = p_r + PW'(integ_r);
    if (ow > P_MAX32) sat_om = 32'sh7FFF_FFFF;
    else if (ow < P_MIN32) sat_om = -32'sh8000_0000;
    else sat_om = ow[31:0];
    ysum = acc_r + AW'(p_r >>> 30);
    if (ysum > AW'(P_MAX32)) y32 = 32'sh7FFF_FFFF;
    else if (ysum < AW'(P_MIN32)) y32 = -32'sh8000_0000;
    else y32 = ysum[31:0];
    new_sign = inj_phase_r ? !inj_sign_r : inj_sign_r;
    r16 = (t17 > 17'd32767) ? 16'sd32767 : signed'(t17[15:0]);
    vsh = p_r >>> 15;
    if (vsh > P_MAX16) vsat = 16'sd32767;
    else if (vsh < P_MIN16) vsat = -16'sd32768;
    else vsat = vsh[15:0];
    idw   = (acc_r + AW'(p_r)) >>> 15;
    cnt_n = count_r + 11'd1;
    sd    = (SW+2)'(id_r) - ((SW+2)'(dd0_r) <<< 1) + (SW+2)'(dd1_r);
    mag   = (sd < 0) ? $unsigned(-(sd >>> 2)) : $unsigned(sd >>> 2);
    ps    = SUMW'(pos_r) + SUMW'(mag);
    ns    = SUMW'(neg_r) + SUMW'(mag);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r   <= '0;
      integ_gain_r  <= '0;
      speed_limit_r <= '1;
      inject_amp_r  <= '0;
      bias_amp_r    <= '0;
      b0_r <= '0;
      a1_r <= '0;
      a2_r <= '0;
      ad0_r <= '0; ad1_r <= '0; bd0_r <= '0; bd1_r <= '0;
      ahp_r <= '0; bhp_r <= '0;
      inj_sign_r  <= 1'b1;
      inj_phase_r <= 1'b0;
      integ_r <= '0;
      xh0_r <= '0; xh1_r <= '0; yh0_r <= '0; yh1_r <= '0;
      angle_r <= '0;
      count_r <= '0;
      dd0_r <= '0; dd1_r <= '0;
      pos_r <= '0; neg_r <= '0;
      detected_r <= 1'b0;
      out_valid  <= 1'b0;
      sel_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_PROP_GAIN:   prop_gain_r   <= cfg_wdata;
          CFG_INTEG_GAIN:  integ_gain_r  <= cfg_wdata;
          CFG_SPEED_LIMIT: speed_limit_r <= cfg_wdata[30:0];
          CFG_INJECT_AMP:  inject_amp_r  <= cfg_wdata[14:0];
          CFG_BIAS_AMP:    bias_amp_r    <= cfg_wdata[14:0];
          CFG_LPF_B0:      b0_r <= signed'(cfg_wdata);
          CFG_LPF_A1:      a1_r <= signed'(cfg_wdata);
          CFG_LPF_A2:      a2_r <= signed'(cfg_wdata);
          default: ;
        endcase
      end
      if (state_r == S_OUT && (!out_valid || out_ready)) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            a_r    <= signed'(ax[SW-1:0]);
            b_r    <= signed'(bx[SW-1:0]);
            kind_r <= in_kind;
            sel_r  <= 1'b0;
          end
        end
        S_Q0: begin
          z_r    <= zc;
          qneg_r <= quad[1];
        end
        S_Q1: z2_r <= t17;
        S_Q4: begin
          if (sel_r) cos_r <= qneg_r ? -r16 : r16;
          else sin_r <= qneg_r ? -r16 : r16;
          sel_r <= 1'b1;
        end
        S_T0: begin
          dha_r <= dha;
          dhb_r <= dhb;
          ahp_r <= hpa;
          bhp_r <= hpb;
          ad1_r <= ad0_r;
          ad0_r <= a_r;
          bd1_r <= bd0_r;
          bd0_r <= b_r;
        end
        S_T2: acc_r <= AW'(p_r);
        S_T3: err_r <= EW'(ed);
        S_T5: integ_r <= iw[31:0];
        S_T6: omega_r <= sat_om;
        S_T8: acc_r <= AW'(p_r >>> 30);
        S_T9: acc_r <= acc_r + AW'(p_r >>> 29);
        S_T10, S_T11: acc_r <= ysum;
        S_T12: begin
          yh1_r <= yh0_r;
          yh0_r <= y32;
          xh1_r <= xh0_r;
          xh0_r <= omega_r;
          angle_r <= angle_r + $unsigned(y32);
          inj_phase_r <= !inj_phase_r;
          inj_sign_r  <= new_sign;
          amp_r <= new_sign ? signed'({1'b0, inject_amp_r}) : -signed'({1'b0, inject_amp_r});
        end
        S_D1: acc_r <= AW'(p_r);
        S_D2: begin
          if (idw > AW'(SMAX_I)) id_r <= SW'(SMAX_I);
          else if (idw < AW'(SMIN_I)) id_r <= SW'(SMIN_I);
          else id_r <= SW'(idw);
        end
        S_D3: begin
          count_r <= cnt_n;
          dd1_r <= dd0_r;
          dd0_r <= id_r;
          if (cnt_n >= DET_POS_START && cnt_n < DET_POS_END) begin
            amp_r <= signed'({1'b0, bias_amp_r});
            if (cnt_n >= DET_POS_SUM)
              pos_r <= (ps > SUMW'(SUM_MAX)) ? SUM_MAX : ps[19:0];
          end else if (cnt_n >= DET_NEG_START && cnt_n < DET_NEG_END) begin
            amp_r <= -signed'({1'b0, bias_amp_r});
            if (cnt_n >= DET_NEG_SUM)
              neg_r <= (ns > SUMW'(SUM_MAX)) ? SUM_MAX : ns[19:0];
          end else begin
            amp_r <= '0;
            if (cnt_n >= DET_NEG_END) begin
              detected_r <= 1'b1;
              if (pos_r < neg_r) begin
                angle_r[31] <= !angle_r[31];
                sin_r <= -sin_r;
                cos_r <= -cos_r;
              end
            end
          end
        end
        S_V1: va_r <= vsat;
        S_V2: vb_r <= vsat;
        S_OUT: begin
          if (!out_valid || out_ready) begin
            out_volt_alpha    <= va_r;
            out_volt_beta     <= vb_r;
            out_angle         <= angle_r[31:16];
            out_speed         <= yh0_r;
            out_polarity_done <= detected_r;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    !$fell(detected_r)) else $error("polarity_done dropped");
  a_count_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    detected_r |=> $stable(count_r)) else $error("detect count moved after completion");
  a_phase_only_track: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_T12) |=> $stable(inj_phase_r)) else $error("injection phase moved");
`endif

endmodule
`default_nettype wire
